@@ hdl/lsp_pkg.sv @@
// lifetime slot pool: shared constants, types and helpers
// used by the controller, datapath and top level; no dependencies
package lsp_pkg;

  localparam int unsigned SLOTS  = 64;
  localparam int unsigned SLOT_W = $clog2(SLOTS);
  localparam int unsigned CNT_W  = $clog2(SLOTS + 1);
  localparam int unsigned LIFE_W = 24;
  localparam int unsigned DT_W   = 16;

  typedef enum logic {
    REQ_SPAWN = 1'b0,
    REQ_TICK  = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TICK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic spawn_start;
    logic tick_start;
    logic scan_step;
    logic tick_step;
    logic load_result;
  } cmd_t;

  typedef struct packed {
    logic spawn_ok;
    logic scan_end;
    logic tick_end;
    logic out_free;
  } sts_t;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] idx);
    logic [SLOT_W-1:0] nxt;
    if (idx == SLOT_W'(SLOTS - 1)) begin
      nxt = '0;
    end else begin
      nxt = idx + SLOT_W'(1);
    end
    return nxt;
  endfunction

endpackage

@@ hdl/lifetime_slot_pool_core.sv @@
// lifetime slot pool top level: controller, datapath and assertions
// depends on lsp_pkg, lsp_ctrl, lsp_dp and lsp_ram
//
// A pool of SLOTS slots, each with an in-use flag and a 12.12 lifetime held in a
// one-port-write, one-port-read ram. Requests are handled one at a time and each
// returns exactly one result beat. A tick streams every slot through the lifetime ram,
// one slot per cycle with the update in the cycle after the read. A successful spawn
// writes the slot and then searches circularly for the next free slot, one slot per cycle.
// A new request is taken while the previous result still waits in the output register.
module lifetime_slot_pool_core import lsp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [23:0] life_time_i,
  input  logic [15:0] tick_delta_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        accepted_o,
  output logic [5:0]  slot_index_o,
  output logic [6:0]  expired_count_o,
  output logic [6:0]  active_count_o
);

  cmd_t cmd;
  sts_t sts;

  lsp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lsp_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .life_time_i     (LIFE_W'(life_time_i)),
    .tick_delta_i    (DT_W'(tick_delta_i)),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .accepted_o      (accepted_o),
    .slot_index_o    (slot_index_o),
    .expired_count_o (expired_count_o),
    .active_count_o  (active_count_o)
  );

  a_active_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (active_count_o <= 7'(SLOTS)))
    else $error("active count above pool size");

  a_spawn_no_expiry : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && accepted_o) |-> (expired_count_o == 7'd0))
    else $error("accepted spawn reports expired slots");

  a_reject_slot_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !accepted_o) |-> (slot_index_o == 6'd0))
    else $error("rejected spawn or tick reports a slot");

  a_tick_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && req_type_i) |=> !in_ready_o)
    else $error("new beat taken while a tick sweep runs");

endmodule

@@ hdl/lsp_ram.sv @@
// generic single write port, single read port ram with registered read
// no dependencies
module lsp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/lsp_ctrl.sv @@
// lifetime slot pool controller: request sequencing state machine
// depends on lsp_pkg
module lsp_ctrl import lsp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic req_type_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (req_e'(req_type_i) == REQ_TICK) begin
            cmd_o.tick_start = 1'b1;
            state_d          = ST_TICK;
          end else begin
            cmd_o.spawn_start = 1'b1;
            state_d           = sts_i.spawn_ok ? ST_SCAN : ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_end) begin
          state_d = ST_DONE;
        end
      end
      ST_TICK: begin
        cmd_o.tick_step = 1'b1;
        if (sts_i.tick_end) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_result = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/lsp_dp.sv @@
// lifetime slot pool datapath: in-use flags, counters, free pointer,
// lifetime ram and result registers; depends on lsp_pkg and lsp_ram
module lsp_dp import lsp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  logic [LIFE_W-1:0] life_time_i,
  input  logic [DT_W-1:0]   tick_delta_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic              accepted_o,
  output logic [5:0]        slot_index_o,
  output logic [6:0]        expired_count_o,
  output logic [6:0]        active_count_o
);

  logic [SLOTS-1:0]  slot_used_q;
  logic [CNT_W-1:0]  used_total_q;
  logic [SLOT_W-1:0] fp_q;
  logic              fp_valid_q;
  logic [SLOT_W-1:0] scan_idx_q;
  logic [SLOT_W-1:0] scan_cnt_q;
  logic [SLOT_W-1:0] rd_idx_q;
  logic              rd_more_q;
  logic [SLOT_W-1:0] st_idx_q;
  logic              st_v_q;
  logic              out_valid_q;

  logic [DT_W-1:0]   dt_q;
  logic              res_acc_q;
  logic [SLOT_W-1:0] res_slot_q;
  logic [CNT_W-1:0]  res_exp_q;
  logic              out_acc_q;
  logic [SLOT_W-1:0] out_slot_q;
  logic [CNT_W-1:0]  out_exp_q;
  logic [CNT_W-1:0]  out_act_q;

  logic              spawn_ok;
  logic              spawn_go;
  logic              scan_free;
  logic              scan_last;
  logic              st_hit;
  logic              st_expire;
  logic [LIFE_W-1:0] life_rd;
  logic [LIFE_W-1:0] dt_ext;
  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  logic [LIFE_W-1:0] ram_wdata;
  logic              ram_re;

  assign spawn_ok  = (used_total_q < CNT_W'(SLOTS)) && fp_valid_q && !slot_used_q[fp_q];
  assign spawn_go  = cmd_i.spawn_start && spawn_ok;
  assign scan_free = !slot_used_q[scan_idx_q];
  assign scan_last = scan_cnt_q == SLOT_W'(SLOTS - 1);
  assign dt_ext    = LIFE_W'(dt_q);
  assign st_hit    = cmd_i.tick_step && st_v_q && slot_used_q[st_idx_q];
  assign st_expire = st_hit && (life_rd <= dt_ext);

  assign ram_we    = spawn_go || (st_hit && !st_expire);
  assign ram_waddr = cmd_i.spawn_start ? fp_q : st_idx_q;
  assign ram_wdata = cmd_i.spawn_start ? life_time_i : (life_rd - dt_ext);
  assign ram_re    = cmd_i.tick_step && rd_more_q;

  lsp_ram #(
    .WIDTH (LIFE_W),
    .DEPTH (SLOTS)
  ) u_life_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_idx_q),
    .rdata_o (life_rd)
  );

  assign sts_o.spawn_ok = spawn_ok;
  assign sts_o.scan_end = scan_free || scan_last;
  assign sts_o.tick_end = st_v_q && (st_idx_q == SLOT_W'(SLOTS - 1));
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_used_q  <= '0;
      used_total_q <= '0;
      fp_q         <= '0;
      fp_valid_q   <= 1'b1;
      scan_idx_q   <= '0;
      scan_cnt_q   <= '0;
      rd_idx_q     <= '0;
      rd_more_q    <= 1'b0;
      st_idx_q     <= '0;
      st_v_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (spawn_go) begin
        slot_used_q[fp_q] <= 1'b1;
        used_total_q      <= used_total_q + CNT_W'(1);
        scan_idx_q        <= next_slot(fp_q);
        scan_cnt_q        <= SLOT_W'(1);
      end
      if (cmd_i.scan_step) begin
        if (scan_free) begin
          fp_q       <= scan_idx_q;
          fp_valid_q <= 1'b1;
        end else if (scan_last) begin
          fp_valid_q <= 1'b0;
        end else begin
          scan_idx_q <= next_slot(scan_idx_q);
          scan_cnt_q <= scan_cnt_q + SLOT_W'(1);
        end
      end
      if (cmd_i.tick_start) begin
        rd_idx_q  <= '0;
        rd_more_q <= 1'b1;
        st_v_q    <= 1'b0;
      end
      if (cmd_i.tick_step) begin
        // read stage one slot ahead of the update stage
        if (rd_more_q) begin
          st_v_q   <= 1'b1;
          st_idx_q <= rd_idx_q;
          if (rd_idx_q == SLOT_W'(SLOTS - 1)) begin
            rd_more_q <= 1'b0;
          end else begin
            rd_idx_q <= rd_idx_q + SLOT_W'(1);
          end
        end else begin
          st_v_q <= 1'b0;
        end
        if (st_expire) begin
          slot_used_q[st_idx_q] <= 1'b0;
          if (used_total_q != '0) begin
            used_total_q <= used_total_q - CNT_W'(1);
          end
          fp_q       <= st_idx_q;
          fp_valid_q <= 1'b1;
        end
      end
      if (cmd_i.load_result) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.spawn_start) begin
      res_acc_q  <= spawn_ok;
      res_slot_q <= spawn_ok ? fp_q : '0;
      res_exp_q  <= '0;
    end
    if (cmd_i.tick_start) begin
      dt_q       <= tick_delta_i;
      res_acc_q  <= 1'b0;
      res_slot_q <= '0;
      res_exp_q  <= '0;
    end
    if (st_expire) begin
      res_exp_q <= res_exp_q + CNT_W'(1);
    end
    if (cmd_i.load_result) begin
      out_acc_q  <= res_acc_q;
      out_slot_q <= res_slot_q;
      out_exp_q  <= res_exp_q;
      out_act_q  <= used_total_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign accepted_o      = out_acc_q;
  assign slot_index_o    = 6'(out_slot_q);
  assign expired_count_o = 7'(out_exp_q);
  assign active_count_o  = 7'(out_act_q);

endmodule
